>>> rtl/gradient_orientation_field_assert.svh
// ----------------------------------------------------------------------------
// gradient_orientation_field_assert.svh
// Assertion macros for the orientation field block; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_ORIENTATION_FIELD_ASSERT_SVH
`define GRADIENT_ORIENTATION_FIELD_ASSERT_SVH

`ifndef SYNTHESIS
// checked only while out of reset
`define GOF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gof assertion failed");
// checked at every edge, reset included
`define GOF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("gof assertion failed");
`else
`define GOF_ASSERT(lbl, clk, rst_n, prop)
`define GOF_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> rtl/gof_pkg.sv
// ----------------------------------------------------------------------------
// gof_pkg
// Shared types and constants of the orientation field block.
// ----------------------------------------------------------------------------
package gof_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int COL_W        = 10;
  localparam int DIM_W        = 11;
  localparam int TENSOR_ROWS  = 64;
  localparam int TROW_W       = 6;
  localparam int WIN_BEHIND   = 7;
  localparam int WIN_AHEAD    = 8;
  localparam int ANGLE_FRAC   = 7;
  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W       = 5;
  localparam int VEC_W        = 53;
  localparam int Z_W          = 27;
  localparam int SUM_W        = 27;

  localparam logic signed [17:0] ANGLE_FULL = 18'sd90 <<< ANGLE_FRAC;
  localparam logic signed [Z_W-1:0] Z_HALF_TURN = 27'sd180 * 27'sd65536;

  // configuration register indexes
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  // atan(2^-i) in 2^-16 degree
  localparam logic signed [Z_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
    27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945, 27'sd234379,
    27'sd117304,  27'sd58666,   27'sd29335,  27'sd14668,  27'sd7334,
    27'sd3667,    27'sd1833,    27'sd917,    27'sd458,    27'sd229,
    27'sd115,     27'sd57,      27'sd29,     27'sd14,     27'sd7
  };

  // gradient products of one pixel
  typedef struct packed {
    logic signed [16:0] xy;
    logic        [15:0] yy;
    logic        [15:0] xx;
  } tensor_t;

  // vertical sum of one column
  typedef struct packed {
    logic signed [21:0] xy;
    logic        [20:0] yy;
    logic        [20:0] xx;
  } colsum_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_stat_t;

endpackage

>>> rtl/gof_cordic.sv
// ----------------------------------------------------------------------------
// gof_cordic
// Iterative vectoring CORDIC, one step a cycle, folded to (-90,90] degrees.
// ----------------------------------------------------------------------------
module gof_cordic import gof_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [SUM_W-1:0] x_i,
  input  logic signed [SUM_W-1:0] y_i,
  output cordic_stat_t            stat_o,
  output logic signed [14:0]      angle_o
);

  logic signed [VEC_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [Z_W-1:0]   z_q, z_d;
  logic [STEP_W-1:0]       i_q, i_d;
  logic                    busy_q, busy_d, done_q, done_d;
  logic signed [14:0]      angle_q, angle_d;

  logic signed [VEC_W-1:0] xs, ys, sx, sy;
  logic signed [Z_W-1:0]   z_step;

  function automatic logic signed [14:0] fold(input logic signed [Z_W-1:0] z);
    logic signed [Z_W:0] zr;
    logic signed [17:0]  p;
    zr = {z[Z_W-1], z} + (28'sd1 <<< (16 - ANGLE_FRAC));
    p  = 18'(zr >>> (17 - ANGLE_FRAC));
    if (p > ANGLE_FULL)   p = p - (ANGLE_FULL <<< 1);
    if (p <= -ANGLE_FULL) p = p + (ANGLE_FULL <<< 1);
    if (p <= 18'sd0) p = p + ANGLE_FULL;
    else             p = p - ANGLE_FULL;
    return p[14:0];
  endfunction

  assign xs = {{2{x_i[SUM_W-1]}}, x_i, 24'b0};
  assign ys = {{2{y_i[SUM_W-1]}}, y_i, 24'b0};
  assign sx = x_q >>> i_q;
  assign sy = y_q >>> i_q;

  always_comb begin
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    i_d     = i_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    angle_d = angle_q;
    z_step  = z_q;
    if (start_i) begin
      i_d = '0;
      if (x_i == '0 && y_i == '0) begin
        done_d  = 1'b1;
        angle_d = fold('0);
      end else if (x_i[SUM_W-1]) begin
        x_d    = -xs;
        y_d    = -ys;
        z_d    = y_i[SUM_W-1] ? -Z_HALF_TURN : Z_HALF_TURN;
        busy_d = 1'b1;
      end else begin
        x_d    = xs;
        y_d    = ys;
        z_d    = '0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (!y_q[VEC_W-1]) begin
        x_d    = x_q + sy;
        y_d    = y_q - sx;
        z_step = z_q + ATAN_TABLE[i_q];
      end else begin
        x_d    = x_q - sy;
        y_d    = y_q + sx;
        z_step = z_q - ATAN_TABLE[i_q];
      end
      z_d = z_step;
      i_d = i_q + STEP_W'(1);
      if (i_q == STEP_W'(CORDIC_STEPS - 1)) begin
        busy_d  = 1'b0;
        done_d  = 1'b1;
        angle_d = fold(z_step);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      i_q    <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    angle_q <= angle_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign angle_o     = angle_q;

endmodule

>>> rtl/gradient_orientation_field.sv
// ----------------------------------------------------------------------------
// gradient_orientation_field
// Local orientation of an RGB raster from box-summed gradient products.
// ----------------------------------------------------------------------------
//
// channel  | dir | fields (lsb first)                      | transfer when
// ---------+-----+-----------------------------------------+----------------
// s_axis   | in  | tdata: red, green, blue; tuser: req_type | tvalid & tready
// m_axis   | out | tdata: angle_value, out_col, out_row;    | tvalid & tready
//          |     | tlast: frame_done                       |
// cfg      | in  | cfg_idx_i: register, cfg_wdata_i: value  | cfg_we_i
//
// Steps: a pixel passes a gray line read, a product write and a check.
// A result adds the tensor fill (a read of each window row for every new
// column, up to 9 columns at column 0), an optional column subtract, the
// CORDIC (start, 20 steps, done) and the load of the output register.
// Throughput is set by the serial column fill and the iterative CORDIC.
// Reset: control and window sums only; memories need no clearing, every entry read in a
// frame was written earlier in that frame. Upstream stalls while a result
// is being formed; downstream stalls hold the result in the output register.
// ----------------------------------------------------------------------------
`include "gradient_orientation_field_assert.svh"

module gradient_orientation_field import gof_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [23:0]      s_axis_tdata,   // red, green, blue
  input  logic             s_axis_tuser,   // req_type
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // angle_value, out_col, out_row, pad
  output logic             m_axis_tlast,   // frame_done
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [DIM_W-1:0] cfg_wdata_i
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_PIX    = 10'b0000000010,
    S_CHK    = 10'b0000000100,
    S_FILL   = 10'b0000001000,
    S_FLWAIT = 10'b0000010000,
    S_SUB    = 10'b0000100000,
    S_SUBW   = 10'b0001000000,
    S_CSTART = 10'b0010000000,
    S_CORDIC = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } gof_state_e;

  gof_state_e state_q, state_d;

  // config and positions
  logic [DIM_W-1:0] img_w_q, img_w_d, img_h_q, img_h_d;
  logic [DIM_W-1:0] in_row_q, in_row_d;
  logic [COL_W-1:0] in_col_q, in_col_d, out_row_q, out_row_d, out_col_q, out_col_d;

  // window state
  logic signed [SUM_W-2:0] win_xx_q, win_xx_d, win_yy_q, win_yy_d, win_xy_q, win_xy_d;
  colsum_t          acc_q, acc_d;
  logic [COL_W-1:0] k_q, k_d, fill_row_q, fill_row_d;
  logic             rd_vld_q;

  // pixel stage
  logic       pix_vld_q, pix_vld_d;
  logic [7:0] gray_q, gray_d;

  // output register
  logic               out_vld_q, out_vld_d, out_done_q, out_done_d;
  logic signed [14:0] out_angle_q, out_angle_d;
  logic [COL_W-1:0]   out_c_q, out_c_d, out_r_q, out_r_d;
  logic               out_free, out_load;

  // memories
  logic [7:0]        gray_mem [MAX_WIDTH];
  logic [7:0]        gray_rd0_q, gray_rd1_q;
  logic              gray_re, gray_we;
  tensor_t           tens_mem [TENSOR_ROWS * MAX_WIDTH];
  tensor_t           tens_rd_q, tens_wdata;
  logic              tens_we, tens_re;
  logic [TROW_W+COL_W-1:0] tens_waddr, tens_raddr;
  colsum_t           col_mem [MAX_WIDTH];
  colsum_t           col_rd_q, col_tot;
  logic              col_we, col_re;
  logic [COL_W-1:0]  col_raddr;

  // derived values
  logic [DIM_W-1:0] w_eff, h_eff, w2, h2, nr, nc, hi11, k_ahead, in_col_p1;
  logic [COL_W-1:0] lo_row, hi_row, last_k;
  logic             ready, frame_last;
  logic [9:0]       rgb_sum;
  logic [19:0]      gray_prod;
  logic signed [8:0]  dx, dy;
  logic signed [17:0] pxx, pyy, pxy;

  // cordic
  logic               cstart;
  cordic_stat_t       cstat;
  logic signed [14:0] cangle;
  logic signed [SUM_W-1:0] cx, cy;

  // clamp geometry
  always_comb begin
    w_eff = (img_w_q < DIM_W'(2)) ? DIM_W'(2) :
            (img_w_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : img_w_q;
    h_eff = (img_h_q < DIM_W'(2)) ? DIM_W'(2) :
            (img_h_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : img_h_q;
  end
  assign w2 = w_eff - DIM_W'(2);
  assign h2 = h_eff - DIM_W'(2);

  // readiness: input must have passed (nc, nr) in raster order
  always_comb begin
    nr = {1'b0, out_row_q} + DIM_W'(WIN_AHEAD + 1);
    if (nr > h_eff - DIM_W'(1)) nr = h_eff - DIM_W'(1);
    nc = {1'b0, out_col_q} + DIM_W'(WIN_AHEAD);
    if (nc > w_eff - DIM_W'(1)) nc = w_eff - DIM_W'(1);
    hi11 = {1'b0, out_row_q} + DIM_W'(WIN_AHEAD);
    if (hi11 > h2) hi11 = h2;
  end
  assign hi_row  = hi11[COL_W-1:0];
  assign lo_row  = (out_row_q >= COL_W'(WIN_BEHIND)) ? out_row_q - COL_W'(WIN_BEHIND) : '0;
  assign last_k  = (w2 < DIM_W'(WIN_AHEAD)) ? w2[COL_W-1:0] : COL_W'(WIN_AHEAD);
  assign k_ahead = {1'b0, out_col_q} + DIM_W'(WIN_AHEAD);
  assign ready   = ({1'b0, out_row_q} <= h2) && ({1'b0, out_col_q} <= w2) &&
                   ((in_row_q > nr) || ((in_row_q == nr) && ({1'b0, in_col_q} > nc)));
  assign frame_last = ({1'b0, out_col_q} == w2) && ({1'b0, out_row_q} == h2);
  assign in_col_p1  = {1'b0, in_col_q} + DIM_W'(1);

  // gray = (r+g+b)/3 via reciprocal, exact for sums up to 765
  assign rgb_sum   = 10'(s_axis_tdata[7:0]) + 10'(s_axis_tdata[15:8]) +
                     10'(s_axis_tdata[23:16]);
  assign gray_prod = 20'(rgb_sum) * 20'd683;

  // forward differences against the stored row above
  assign dx  = $signed({1'b0, gray_rd1_q}) - $signed({1'b0, gray_rd0_q});
  assign dy  = $signed({1'b0, gray_q})     - $signed({1'b0, gray_rd0_q});
  assign pxx = dx * dx;
  assign pyy = dy * dy;
  assign pxy = dx * dy;
  assign tens_wdata.xx = pxx[15:0];
  assign tens_wdata.yy = pyy[15:0];
  assign tens_wdata.xy = pxy[16:0];
  assign tens_waddr    = {TROW_W'(in_row_q - DIM_W'(1)), in_col_q};
  assign tens_raddr    = {fill_row_q[TROW_W-1:0], k_q};
  assign col_raddr     = out_col_q - COL_W'(WIN_AHEAD);

  // column total = running accumulation + last row read
  always_comb begin
    col_tot.xx = acc_q.xx + 21'(tens_rd_q.xx);
    col_tot.yy = acc_q.yy + 21'(tens_rd_q.yy);
    col_tot.xy = acc_q.xy + 22'(tens_rd_q.xy);
  end

  assign cx = SUM_W'(win_xx_q) - SUM_W'(win_yy_q);
  assign cy = {win_xy_q, 1'b0};

  assign out_free = !out_vld_q || m_axis_tready;
  assign out_load = (state_q == S_OUT) && out_free;

  always_comb begin
    state_d     = state_q;
    img_w_d     = img_w_q;
    img_h_d     = img_h_q;
    in_row_d    = in_row_q;
    in_col_d    = in_col_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    win_xx_d    = win_xx_q;
    win_yy_d    = win_yy_q;
    win_xy_d    = win_xy_q;
    acc_d       = acc_q;
    k_d         = k_q;
    fill_row_d  = fill_row_q;
    pix_vld_d   = pix_vld_q;
    gray_d      = gray_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_done_d  = out_done_q;
    out_angle_d = out_angle_q;
    out_c_d     = out_c_q;
    out_r_d     = out_r_q;
    gray_re     = 1'b0;
    gray_we     = 1'b0;
    tens_we     = 1'b0;
    tens_re     = 1'b0;
    col_we      = 1'b0;
    col_re      = 1'b0;
    cstart      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          pix_vld_d = !s_axis_tuser && (in_row_q < h_eff);
          gray_d    = gray_prod[18:11];
          gray_re   = 1'b1;
          state_d   = pix_vld_d ? S_PIX : S_CHK;
        end
      end
      S_PIX: begin
        gray_we = 1'b1;
        tens_we = (in_row_q != '0) && ({1'b0, in_col_q} <= w2);
        if (in_col_p1 >= w_eff) begin
          in_col_d = '0;
          in_row_d = in_row_q + DIM_W'(1);
        end else begin
          in_col_d = in_col_p1[COL_W-1:0];
        end
        state_d = S_CHK;
      end
      S_CHK: begin
        acc_d = '0;
        if (!ready) begin
          state_d = S_IDLE;
        end else if (out_col_q == '0) begin
          win_xx_d   = '0;
          win_yy_d   = '0;
          win_xy_d   = '0;
          k_d        = '0;
          fill_row_d = lo_row;
          state_d    = S_FILL;
        end else if (k_ahead <= w2) begin
          k_d        = k_ahead[COL_W-1:0];
          fill_row_d = lo_row;
          state_d    = S_FILL;
        end else if (out_col_q >= COL_W'(WIN_BEHIND + 1)) begin
          state_d = S_SUB;
        end else begin
          state_d = S_CSTART;
        end
      end
      S_FILL: begin
        tens_re = 1'b1;
        if (rd_vld_q) acc_d = col_tot;
        if (fill_row_q == hi_row) state_d = S_FLWAIT;
        else fill_row_d = fill_row_q + COL_W'(1);
      end
      S_FLWAIT: begin
        col_we   = 1'b1;
        acc_d    = '0;
        win_xx_d = win_xx_q + $signed({5'b0, col_tot.xx});
        win_yy_d = win_yy_q + $signed({5'b0, col_tot.yy});
        win_xy_d = win_xy_q + 26'(col_tot.xy);
        if (out_col_q == '0) begin
          if (k_q < last_k) begin
            k_d        = k_q + COL_W'(1);
            fill_row_d = lo_row;
            state_d    = S_FILL;
          end else begin
            state_d = S_CSTART;
          end
        end else if (out_col_q >= COL_W'(WIN_BEHIND + 1)) begin
          state_d = S_SUB;
        end else begin
          state_d = S_CSTART;
        end
      end
      S_SUB: begin
        col_re  = 1'b1;
        state_d = S_SUBW;
      end
      S_SUBW: begin
        win_xx_d = win_xx_q - $signed({5'b0, col_rd_q.xx});
        win_yy_d = win_yy_q - $signed({5'b0, col_rd_q.yy});
        win_xy_d = win_xy_q - 26'(col_rd_q.xy);
        state_d  = S_CSTART;
      end
      S_CSTART: begin
        cstart  = 1'b1;
        state_d = S_CORDIC;
      end
      S_CORDIC: begin
        if (cstat.done) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_vld_d   = 1'b1;
          out_angle_d = cangle;
          out_c_d     = out_col_q;
          out_r_d     = out_row_q;
          out_done_d  = frame_last;
          if ({1'b0, out_col_q} + DIM_W'(1) == w_eff - DIM_W'(1)) begin
            out_col_d = '0;
            out_row_d = out_row_q + COL_W'(1);
          end else begin
            out_col_d = out_col_q + COL_W'(1);
          end
          if (frame_last) begin
            in_row_d  = '0;
            in_col_d  = '0;
            out_row_d = '0;
            out_col_d = '0;
            win_xx_d  = '0;
            win_yy_d  = '0;
            win_xy_d  = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // register write restarts the frame
    if (cfg_we_i) begin
      if (cfg_idx_i == CFG_IMAGE_WIDTH) img_w_d = cfg_wdata_i;
      else                              img_h_d = cfg_wdata_i;
      in_row_d  = '0;
      in_col_d  = '0;
      out_row_d = '0;
      out_col_d = '0;
      win_xx_d  = '0;
      win_yy_d  = '0;
      win_xy_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      img_w_q   <= DIM_W'(MAX_WIDTH);
      img_h_q   <= DIM_W'(MAX_WIDTH);
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      win_xx_q  <= '0;
      win_yy_q  <= '0;
      win_xy_q  <= '0;
      out_vld_q <= 1'b0;
      rd_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      img_w_q   <= img_w_d;
      img_h_q   <= img_h_d;
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
      win_xx_q  <= win_xx_d;
      win_yy_q  <= win_yy_d;
      win_xy_q  <= win_xy_d;
      out_vld_q <= out_vld_d;
      rd_vld_q  <= tens_re;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    k_q         <= k_d;
    fill_row_q  <= fill_row_d;
    pix_vld_q   <= pix_vld_d;
    gray_q      <= gray_d;
    out_done_q  <= out_done_d;
    out_angle_q <= out_angle_d;
    out_c_q     <= out_c_d;
    out_r_q     <= out_r_d;
  end

  // gray line of the row above
  always_ff @(posedge clk_i) begin
    if (gray_we && pix_vld_q) gray_mem[in_col_q] <= gray_q;
    if (gray_re) begin
      gray_rd0_q <= gray_mem[in_col_q];
      gray_rd1_q <= gray_mem[in_col_q + COL_W'(1)];
    end
  end

  // product ring, 64 rows deep
  always_ff @(posedge clk_i) begin
    if (tens_we) tens_mem[tens_waddr] <= tens_wdata;
    if (tens_re) tens_rd_q <= tens_mem[tens_raddr];
  end

  // per-column vertical sums
  always_ff @(posedge clk_i) begin
    if (col_we) col_mem[k_q] <= col_tot;
    if (col_re) col_rd_q <= col_mem[col_raddr];
  end

  gof_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cstart),
    .x_i     (cx),
    .y_i     (cy),
    .stat_o  (cstat),
    .angle_o (cangle)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = out_done_q;
  assign m_axis_tdata  = {5'b0, out_r_q, out_c_q, out_angle_q};

  `GOF_ASSERT(a_fill_row_bound, clk_i, rst_ni, (state_q == S_FILL) |-> (fill_row_q <= hi_row))
  `GOF_ASSERT(a_load_shows, clk_i, rst_ni, out_load |=> m_axis_tvalid)
  `GOF_ASSERT(a_cordic_done_wait, clk_i, rst_ni, cstat.done |-> (state_q == S_CORDIC))
  `GOF_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> (!m_axis_tvalid && s_axis_tready))

endmodule
